>>> rtl/delta_timer_queue_unit_defines.svh
// Assertion macros for the delta timer queue checker
`ifndef DELTA_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELTA_TIMER_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define DTQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtq check failed");

// next-cycle implication, masked during reset
`define DTQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtq check failed");

`endif

>>> rtl/dtq_pkg.sv
// Types and codes for the delta timer queue
package dtq_pkg;

   // request codes
   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_RESET  = 3'd2;
   localparam logic [2:0] REQ_QUERY  = 3'd3;
   localparam logic [2:0] REQ_TICK   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EXPIRED  = 2'd3;

   // most timers released by one tick
   localparam int MAX_EXPIRE = 16;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] timer_ref;
      logic [31:0] amount_ms;
      logic [31:0] user_tag;
   } dtq_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] timer_id;
      logic [31:0] tag_out;
      logic [31:0] remaining_ms;
      logic        queue_empty;
      logic [31:0] next_due_ms;
      logic        last;
   } dtq_rsp_type;

   // one slot of the delta list
   typedef struct packed {
      logic [31:0] delta;
      logic [15:0] ident;
      logic [31:0] tag;
   } dtq_entry_type;

endpackage

>>> rtl/delta_timer_queue_unit.sv
// Delta-list timer queue: sequencer, slot memory and shared 33-bit adder
//
//   channel | signals                          | moves
//   --------+----------------------------------+-----------------------------------
//   req     | req_valid, req_ready, req_data   | one request item in
//   rsp     | rsp_valid, rsp_ready, rsp_data   | result items out, last marks end
//
// One request at a time; req_ready is high only while the sequencer is idle.
// The slot memory is walked and shifted at one entry per cycle through a single
// read and a single write port: an add walks to its slot and shifts the tail up,
// delete/reset/query search by id (a reset then re-inserts), a tick walks expiring
// heads and shifts the rest down. A stalled rsp side holds the sequencer only when
// it has a further item to hand over. Reset clears the counts; slots need no clear.
module delta_timer_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dtq_pkg::dtq_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dtq_pkg::dtq_rsp_type rsp_data
);
   import dtq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP   = (DEPTH < MAX_EXPIRE) ? DEPTH : MAX_EXPIRE;
   localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAP);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INS_START = 4'd1;
   localparam logic [3:0] S_INS_WALK  = 4'd2;
   localparam logic [3:0] S_INS_SHIFT = 4'd3;
   localparam logic [3:0] S_INS_FIX   = 4'd4;
   localparam logic [3:0] S_INS_PUT   = 4'd5;
   localparam logic [3:0] S_FIND      = 4'd6;
   localparam logic [3:0] S_DEL_SHIFT = 4'd7;
   localparam logic [3:0] S_TICK_WALK = 4'd8;
   localparam logic [3:0] S_TICK_CAP  = 4'd9;
   localparam logic [3:0] S_EMIT_RD   = 4'd10;
   localparam logic [3:0] S_EMIT_OUT  = 4'd11;
   localparam logic [3:0] S_TK_SHIFT  = 4'd12;
   localparam logic [3:0] S_HEAD_RD   = 4'd13;
   localparam logic [3:0] S_HEAD_GET  = 4'd14;
   localparam logic [3:0] S_RESP      = 4'd15;

   // control registers
   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [15:0]      id_ctr_ff, id_ctr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] nexp_ff, nexp_in;
   logic [2:0]       type_ff, type_in;
   logic [15:0]      ref_ff, ref_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      sum_ff, sum_in;
   logic [31:0]      head_ff, head_in;
   logic [31:0]      tag_ff, tag_in;
   dtq_entry_type    sav_ff, sav_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [15:0]      res_id_ff, res_id_in;
   logic [31:0]      res_rem_ff, res_rem_in;
   dtq_rsp_type      rsp_ff, rsp_in;

   // slot memory
   dtq_entry_type    mem [DEPTH];
   dtq_entry_type    rd_q_ff;
   logic [IDX_W-1:0] rd_a;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   dtq_entry_type    mem_wd;

   // shared adder / subtractor
   logic [31:0] op_a, op_b;
   logic        op_sub;
   logic [32:0] unit_res;
   logic        unit_co;
   logic [31:0] unit_sat;

   logic [CNT_W-1:0] idx_p1, idx_m1, nexp_p1;
   logic [15:0]      id_next;
   logic             out_free;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign idx_p1  = idx_ff + ONE_C;
   assign idx_m1  = idx_ff - ONE_C;
   assign nexp_p1 = nexp_ff + ONE_C;
   assign id_next = (id_ctr_ff == 16'hFFFF) ? 16'd1 : id_ctr_ff + 16'd1;

   // adder operand selection: a + b, or a - b with carry out meaning no borrow
   always_comb begin
      op_a   = rem_ff;
      op_b   = rd_q_ff.delta;
      op_sub = 1'b1;
      case (state_ff)
         S_INS_FIX: begin
            op_a = sav_ff.delta;
            op_b = rem_ff;
         end
         S_FIND: begin
            op_a   = sum_ff;
            op_sub = 1'b0;
         end
         S_DEL_SHIFT: begin
            op_a   = rd_q_ff.delta;
            op_b   = sav_ff.delta;
            op_sub = 1'b0;
         end
         S_TICK_CAP: begin
            op_a = rd_q_ff.delta;
            op_b = rem_ff;
         end
         default: begin
         end
      endcase
   end

   assign unit_res = {1'b0, op_a} + {1'b0, op_b ^ {32{op_sub}}} + {32'd0, op_sub};
   assign unit_co  = unit_res[32];
   assign unit_sat = unit_co ? 32'hFFFF_FFFF : unit_res[31:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      id_ctr_in     = id_ctr_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      nexp_in       = nexp_ff;
      type_in       = type_ff;
      ref_in        = ref_ff;
      rem_in        = rem_ff;
      sum_in        = sum_ff;
      head_in       = head_ff;
      tag_in        = tag_ff;
      sav_in        = sav_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_rem_in    = res_rem_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_a          = idx_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      mem_wa        = idx_ff[IDX_W-1:0];
      mem_wd        = rd_q_ff;

      case (state_ff)
         S_IDLE: begin
            rd_a = '0;
            if (accept) begin
               type_in       = req_data.req_type;
               ref_in        = req_data.timer_ref;
               rem_in        = req_data.amount_ms;
               tag_in        = req_data.user_tag;
               sum_in        = '0;
               idx_in        = '0;
               nexp_in       = '0;
               res_status_in = ST_OK;
               res_id_in     = '0;
               res_rem_in    = '0;
               state_in      = S_HEAD_RD;
               case (req_data.req_type)
                  REQ_ADD: begin
                     if (live_ff == DEPTH_C) begin
                        res_status_in = ST_FULL;
                     end else begin
                        id_ctr_in = id_next;
                        res_id_in = id_next;
                        state_in  = S_INS_START;
                     end
                  end
                  REQ_DELETE, REQ_RESET, REQ_QUERY: begin
                     res_id_in = req_data.timer_ref;
                     if (req_data.timer_ref == '0 || live_ff == '0) begin
                        res_status_in = ST_NOTFOUND;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  REQ_TICK: begin
                     if (live_ff != '0) begin
                        state_in = S_TICK_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // insert: walk to the slot, open a gap, rebase the follower, write
         S_INS_START: begin
            rd_a   = '0;
            idx_in = '0;
            if (live_ff == '0) begin
               pos_in   = '0;
               state_in = S_INS_PUT;
            end else begin
               state_in = S_INS_WALK;
            end
         end
         S_INS_WALK: begin
            if (!unit_co) begin
               pos_in = idx_ff;
               sav_in = rd_q_ff;
               if (idx_p1 < live_ff) begin
                  idx_in   = live_ff - ONE_C;
                  rd_a     = idx_in[IDX_W-1:0];
                  state_in = S_INS_SHIFT;
               end else begin
                  state_in = S_INS_FIX;
               end
            end else begin
               rem_in = unit_res[31:0];
               if (idx_p1 < live_ff) begin
                  idx_in = idx_p1;
                  rd_a   = idx_p1[IDX_W-1:0];
               end else begin
                  pos_in   = live_ff;
                  state_in = S_INS_PUT;
               end
            end
         end
         S_INS_SHIFT: begin
            mem_we = 1'b1;
            mem_wa = idx_p1[IDX_W-1:0];
            if (idx_m1 > pos_ff) begin
               idx_in = idx_m1;
               rd_a   = idx_m1[IDX_W-1:0];
            end else begin
               state_in = S_INS_FIX;
            end
         end
         S_INS_FIX: begin
            mem_we       = 1'b1;
            mem_wa       = IDX_W'(pos_ff + ONE_C);
            mem_wd       = sav_ff;
            mem_wd.delta = unit_res[31:0];
            state_in     = S_INS_PUT;
         end
         S_INS_PUT: begin
            mem_we       = 1'b1;
            mem_wa       = pos_ff[IDX_W-1:0];
            mem_wd.delta = rem_ff;
            mem_wd.ident = res_id_ff;
            mem_wd.tag   = tag_ff;
            live_in      = live_ff + ONE_C;
            state_in     = S_HEAD_RD;
         end

         // lookup by id, summing deltas on the way
         S_FIND: begin
            if (rd_q_ff.ident == ref_ff) begin
               if (type_ff == REQ_QUERY) begin
                  res_rem_in = unit_sat;
                  state_in   = S_HEAD_RD;
               end else begin
                  pos_in = idx_ff;
                  tag_in = rd_q_ff.tag;
                  sav_in = rd_q_ff;
                  if (idx_p1 < live_ff) begin
                     idx_in   = idx_p1;
                     rd_a     = idx_p1[IDX_W-1:0];
                     state_in = S_DEL_SHIFT;
                  end else begin
                     live_in  = live_ff - ONE_C;
                     state_in = (type_ff == REQ_RESET) ? S_INS_START : S_HEAD_RD;
                  end
               end
            end else if (idx_p1 < live_ff) begin
               sum_in = unit_sat;
               idx_in = idx_p1;
               rd_a   = idx_p1[IDX_W-1:0];
            end else begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_HEAD_RD;
            end
         end

         // close the gap; the first follower absorbs the removed delta
         S_DEL_SHIFT: begin
            mem_we       = 1'b1;
            mem_wa       = idx_m1[IDX_W-1:0];
            mem_wd.delta = unit_sat;
            sav_in.delta = '0;
            if (idx_p1 < live_ff) begin
               idx_in = idx_p1;
               rd_a   = idx_p1[IDX_W-1:0];
            end else begin
               live_in  = live_ff - ONE_C;
               state_in = (type_ff == REQ_RESET) ? S_INS_START : S_HEAD_RD;
            end
         end

         // tick: count expiring heads, rebase the new head, report each expired timer, shift the rest down
         S_TICK_WALK: begin
            if (unit_co) begin
               rem_in  = unit_res[31:0];
               nexp_in = nexp_p1;
               if (idx_p1 < live_ff) begin
                  idx_in = idx_p1;
                  rd_a   = idx_p1[IDX_W-1:0];
                  if (!(nexp_p1 < CAP_C)) begin
                     state_in = S_TICK_CAP;
                  end
               end else begin
                  head_in  = '0;
                  idx_in   = '0;
                  state_in = S_EMIT_RD;
               end
            end else begin
               state_in = S_TICK_CAP;
            end
         end
         S_TICK_CAP: begin
            head_in      = unit_co ? unit_res[31:0] : 32'd0;
            mem_we       = 1'b1;
            mem_wd.delta = head_in;
            idx_in       = '0;
            state_in     = (nexp_ff == '0) ? S_RESP : S_EMIT_RD;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = ST_EXPIRED;
               rsp_in.timer_id     = rd_q_ff.ident;
               rsp_in.tag_out      = rd_q_ff.tag;
               rsp_in.remaining_ms = '0;
               rsp_in.queue_empty  = (live_ff == nexp_ff);
               rsp_in.next_due_ms  = head_ff;
               rsp_in.last         = (idx_p1 == nexp_ff);
               if (idx_p1 == nexp_ff) begin
                  if (live_ff == nexp_ff) begin
                     live_in  = '0;
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = nexp_ff;
                     rd_a     = nexp_ff[IDX_W-1:0];
                     state_in = S_TK_SHIFT;
                  end
               end else begin
                  idx_in   = idx_p1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_TK_SHIFT: begin
            mem_we = 1'b1;
            mem_wa = IDX_W'(idx_ff - nexp_ff);
            if (idx_p1 < live_ff) begin
               idx_in = idx_p1;
               rd_a   = idx_p1[IDX_W-1:0];
            end else begin
               live_in  = live_ff - nexp_ff;
               state_in = S_IDLE;
            end
         end

         // single result: fetch head delta then hand the item over
         S_HEAD_RD: begin
            rd_a     = '0;
            state_in = S_HEAD_GET;
         end
         S_HEAD_GET: begin
            head_in  = rd_q_ff.delta;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = res_status_ff;
               rsp_in.timer_id     = res_id_ff;
               rsp_in.tag_out      = '0;
               rsp_in.remaining_ms = res_rem_ff;
               rsp_in.queue_empty  = (live_ff == '0);
               rsp_in.next_due_ms  = (live_ff == '0) ? 32'd0 : head_ff;
               rsp_in.last         = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         id_ctr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      nexp_ff       <= nexp_in;
      type_ff       <= type_in;
      ref_ff        <= ref_in;
      rem_ff        <= rem_in;
      sum_ff        <= sum_in;
      head_ff       <= head_in;
      tag_ff        <= tag_in;
      sav_ff        <= sav_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_rem_ff    <= res_rem_in;
      rsp_ff        <= rsp_in;
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[rd_a];
   end

endmodule

>>> rtl/dtq_checker.sv
// Port-level checks for the delta timer queue, bound to the top level
`include "delta_timer_queue_unit_defines.svh"

module dtq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input dtq_pkg::dtq_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dtq_pkg::dtq_rsp_type rsp_data
);
   import dtq_pkg::*;

   // a stalled result item holds
   `DTQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // one request at a time: busy straight after an accept
   `DTQ_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // an empty queue has nothing due
   `DTQ_ASSERT_IMP(a_empty_no_due, clock, reset, rsp_valid && rsp_data.queue_empty, rsp_data.next_due_ms == 32'd0)

   // expired items carry a real id and no remaining time
   `DTQ_ASSERT_IMP(a_expired_id, clock, reset, rsp_valid && rsp_data.status == ST_EXPIRED, rsp_data.timer_id != 16'd0 && rsp_data.remaining_ms == 32'd0)

   // only expiry produces multi-item answers
   `DTQ_ASSERT_IMP(a_single_last, clock, reset, rsp_valid && rsp_data.status != ST_EXPIRED, rsp_data.last)

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (.*);

>>> test/delta_timer_queue_unit_tb.sv
// Self-checking testbench for the delta timer queue: random and directed requests, result check
module delta_timer_queue_unit_tb;
   import dtq_pkg::*;

   localparam int SLOTS      = 16;
   localparam int ITEM_TOTAL = 380;
   localparam int HOLD_START = 1200;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 100;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dtq_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dtq_rsp_type rsp_data;

   // items waiting for the driver, results still owed by the block
   dtq_req_type req_backlog_q[$];
   dtq_rsp_type timer_results_due_q[$];

   int tx_idle_pct = 28;
   int rx_idle_pct = 73;
   int rx_cycle;
   int mismatch_count = 0;

   // shadow of the delta list
   logic [31:0] due_gap  [SLOTS];
   logic [15:0] owner_id [SLOTS];
   logic [31:0] owner_tag[SLOTS];
   int          pending_count = 0;
   logic [15:0] id_seq = '0;

   delta_timer_queue_unit #(.DEPTH(SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic int locate_timer(logic [15:0] ref_id);
      int i;
      if (ref_id == 16'd0) return -1;
      for (i = 0; i < pending_count; i++)
         if (owner_id[i] == ref_id) return i;
      return -1;
   endfunction

   // close the gap left by an entry, no delta merge
   function automatic void drop_entry(int pos);
      int i;
      for (i = pos; i + 1 < pending_count; i++) begin
         due_gap[i]   = due_gap[i + 1];
         owner_id[i]  = owner_id[i + 1];
         owner_tag[i] = owner_tag[i + 1];
      end
      pending_count--;
   endfunction

   // removal hands the entry's delta on to its successor
   function automatic void unlink_timer(int pos);
      if (pos + 1 < pending_count)
         due_gap[pos + 1] = sat_sum(due_gap[pos + 1], due_gap[pos]);
      drop_entry(pos);
   endfunction

   // insert after every entry due at or before the new one
   function automatic void place_timer(logic [15:0] ident, logic [31:0] tag,
                                       logic [31:0] amount);
      int pos;
      int i;
      logic [31:0] left;
      pos  = 0;
      left = amount;
      while (pos < pending_count) begin
         if (left < due_gap[pos]) begin
            due_gap[pos] = due_gap[pos] - left;
            break;
         end
         left = left - due_gap[pos];
         pos++;
      end
      for (i = pending_count; i > pos; i--) begin
         due_gap[i]   = due_gap[i - 1];
         owner_id[i]  = owner_id[i - 1];
         owner_tag[i] = owner_tag[i - 1];
      end
      due_gap[pos]   = left;
      owner_id[pos]  = ident;
      owner_tag[pos] = tag;
      pending_count++;
   endfunction

   // apply one request to the shadow list and queue the results it owes
   function automatic void compute_timer_results(dtq_req_type r);
      dtq_rsp_type res[$];
      dtq_rsp_type one;
      int          pos;
      int          i;
      logic [31:0] left;
      logic [31:0] kept;
      one = '0;
      case (r.req_type)
         REQ_ADD: begin
            if (pending_count >= SLOTS) begin
               one.status = ST_FULL;
            end else begin
               id_seq = id_seq + 16'd1;
               if (id_seq == 16'd0) id_seq = 16'd1;
               place_timer(id_seq, r.user_tag, r.amount_ms);
               one.timer_id = id_seq;
            end
            res.push_back(one);
         end
         REQ_DELETE, REQ_RESET, REQ_QUERY: begin
            pos = locate_timer(r.timer_ref);
            one.timer_id = r.timer_ref;
            if (pos < 0) begin
               one.status = ST_NOTFOUND;
            end else if (r.req_type == REQ_DELETE) begin
               unlink_timer(pos);
            end else if (r.req_type == REQ_RESET) begin
               kept = owner_tag[pos];
               unlink_timer(pos);
               place_timer(r.timer_ref, kept, r.amount_ms);
            end else begin
               left = '0;
               for (i = 0; i <= pos; i++) left = sat_sum(left, due_gap[i]);
               one.remaining_ms = left;
            end
            res.push_back(one);
         end
         REQ_TICK: begin
            left = r.amount_ms;
            while (pending_count > 0 && res.size() < MAX_EXPIRE) begin
               if (due_gap[0] > left) begin
                  due_gap[0] = due_gap[0] - left;
                  left = '0;
                  break;
               end
               left = left - due_gap[0];
               one.status   = ST_EXPIRED;
               one.timer_id = owner_id[0];
               one.tag_out  = owner_tag[0];
               res.push_back(one);
               drop_entry(0);
            end
            // cap reached: leftover time eats into the new head, floor at zero
            if (left != 0 && pending_count > 0)
               due_gap[0] = (due_gap[0] > left) ? due_gap[0] - left : 32'd0;
            if (res.size() == 0) begin
               one = '0;
               res.push_back(one);
            end
         end
         default: res.push_back(one);
      endcase
      foreach (res[k]) begin
         res[k].queue_empty = (pending_count == 0);
         res[k].next_due_ms = (pending_count == 0) ? 32'd0 : due_gap[0];
         res[k].last        = (k == res.size() - 1);
         timer_results_due_q.push_back(res[k]);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < 50)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // driver: next item only once the current one has gone
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle  <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // monitor: predict on request accept, then check any result at this edge
   always @(posedge clock) begin
      dtq_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) compute_timer_results(req_data);
         if (rsp_valid && rsp_ready) begin
            if (timer_results_due_q.size() == 0) begin
               if (mismatch_count < 50)
                  $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = timer_results_due_q.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("timer_id", want.timer_id, rsp_data.timer_id);
               check_field("tag_out", want.tag_out, rsp_data.tag_out);
               check_field("remaining_ms", want.remaining_ms, rsp_data.remaining_ms);
               check_field("queue_empty", want.queue_empty, rsp_data.queue_empty);
               check_field("next_due_ms", want.next_due_ms, rsp_data.next_due_ms);
               check_field("last", want.last, rsp_data.last);
            end
         end
      end
   end

   // keep the backlog short so picked ids are still mostly live
   task automatic offer(logic [2:0] kind, logic [15:0] ref_id, logic [31:0] amount,
                        logic [31:0] tag);
      dtq_req_type item;
      item.req_type  = kind;
      item.timer_ref = ref_id;
      item.amount_ms = amount;
      item.user_tag  = tag;
      while (req_backlog_q.size() >= 4) @(posedge clock);
      req_backlog_q.push_back(item);
   endtask

   function automatic logic [15:0] pick_ref();
      int r;
      r = $urandom_range(19);
      if (pending_count > 0 && r < 16) return owner_id[$urandom_range(pending_count - 1)];
      if (r < 19) return 16'($urandom_range(65535));
      return 16'd0;
   endfunction

   function automatic logic [31:0] timeout_span();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 32'd0;
      if (r < 80) return 32'($urandom_range(1, 200));
      if (r < 90) return 32'($urandom_range(201, 5000));
      return $urandom;
   endfunction

   function automatic logic [31:0] tick_span();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 32'd0;
      if (r < 85) return 32'($urandom_range(1, 120));
      if (r < 93) return 32'($urandom_range(121, 3000));
      return $urandom;
   endfunction

   // stimulus
   initial begin
      int sent;
      int r;
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table: zero id, unknown id, idle tick
      offer(REQ_QUERY, 16'd0, 32'd0, 32'd0);
      offer(REQ_DELETE, 16'h1234, 32'd0, 32'd0);
      offer(REQ_TICK, 16'd0, 32'd0, 32'd0);
      // ids 1..4, extremes of timeout and tag, a pair due together
      offer(REQ_ADD, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
      offer(REQ_ADD, 16'd0, 32'hFFFF_FFFF, 32'd0);
      offer(REQ_ADD, 16'd0, 32'd100, 32'hA5A5_0001);
      offer(REQ_ADD, 16'd0, 32'd100, 32'h5A5A_0002);
      // zero tick releases the zero-delay head
      offer(REQ_TICK, 16'd0, 32'd0, 32'd0);
      offer(REQ_TICK, 16'd0, 32'd50, 32'd0);
      // id 5 lands last, due 2^32-1 ms from now: query of the largest sum
      offer(REQ_ADD, 16'd0, 32'hFFFF_FFFF, 32'h0BAD_CAFE);
      offer(REQ_QUERY, 16'd5, 32'd0, 32'd0);
      offer(REQ_QUERY, 16'd4, 32'd0, 32'd0);
      // deleting id 2 merges its delta into its follower
      offer(REQ_DELETE, 16'd2, 32'd0, 32'd0);
      offer(REQ_RESET, 16'd0, 32'd7, 32'd0);
      offer(REQ_QUERY, 16'hFFFF, 32'd0, 32'd0);
      offer(REQ_RESET, 16'd4, 32'd10, 32'hFFFF_FFFF);
      offer(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(3'd6, 16'h8001, 32'h8000_0001, 32'h8000_0001);
      offer(3'd7, 16'd0, 32'd0, 32'd0);
      // equal due times leave first in, first out
      offer(REQ_ADD, 16'd0, 32'd5, 32'h1111_1111);
      offer(REQ_ADD, 16'd0, 32'd5, 32'h2222_2222);
      offer(REQ_TICK, 16'd0, 32'd60, 32'd0);
      offer(REQ_TICK, 16'd0, 32'hFFFF_FFFF, 32'd0);
      sent = 20;

      // random traffic, mostly well-formed against live ids
      while (sent < ITEM_TOTAL) begin
         if (sent >= 2 * ITEM_TOTAL / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (sent >= ITEM_TOTAL / 3) begin
            tx_idle_pct = 73;
            rx_idle_pct = 28;
         end
         r = $urandom_range(199);
         if (r < 3) begin
            // run the table into full
            for (k = 0; k < 17; k++)
               offer(REQ_ADD, 16'($urandom), timeout_span(), $urandom);
            sent += 17;
         end else if (r < 73) begin
            offer(REQ_ADD, 16'($urandom), timeout_span(), $urandom);
            sent++;
         end else if (r < 123) begin
            offer(REQ_TICK, 16'($urandom), tick_span(), $urandom);
            sent++;
         end else if (r < 147) begin
            offer(REQ_DELETE, pick_ref(), $urandom, $urandom);
            sent++;
         end else if (r < 163) begin
            offer(REQ_RESET, pick_ref(), timeout_span(), $urandom);
            sent++;
         end else if (r < 190) begin
            offer(REQ_QUERY, pick_ref(), $urandom, $urandom);
            sent++;
         end else begin
            offer(3'($urandom_range(5, 7)), 16'($urandom), $urandom, $urandom);
         end
      end

      // drain, then allow for stray results
      while (req_backlog_q.size() > 0 || req_valid || timer_results_due_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && timer_results_due_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #15_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dtq_pkg.sv
rtl/delta_timer_queue_unit.sv
rtl/dtq_checker.sv
test/delta_timer_queue_unit_tb.sv
